[design/sdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the session data envelope deframer.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam logic [7:0] MAP_HEAD      = 8'ha1;
  localparam logic [7:0] KEY_HEAD      = 8'h64;
  localparam logic [7:0] BSTR_INL_LO   = 8'h40;
  localparam logic [7:0] BSTR_INL_HI   = 8'h57;
  localparam logic [7:0] BSTR_LEN8     = 8'h58;
  localparam logic [7:0] BSTR_LEN16    = 8'h59;
  localparam logic [2:0] HEAD_LEN      = 3'd6;
  localparam logic [15:0] CAPACITY_RST = 16'd512;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CIPHER = 2'd1;
  localparam logic [1:0] KIND_TAG    = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HEAD  = 3'd1;
  localparam logic [2:0] ST_BAD_CODE  = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_BELOW_TAG = 3'd4;
  localparam logic [2:0] ST_OVER_CAP  = 3'd5;

  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  kind;
    logic        done;
    logic [2:0]  status;
    logic [15:0] cipher_len;
  } sdf_result_t;

  function automatic logic [7:0] head_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = MAP_HEAD;
      3'd1: b = KEY_HEAD;
      3'd2: b = 8'h64;
      3'd3: b = 8'h61;
      3'd4: b = 8'h74;
      3'd5: b = 8'h61;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[design/sdf_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_parser
// Message state machine: checks the head, decodes the byte-string length,
// classifies body bytes and forms one result per beat.
// ----------------------------------------------------------------------------
module sdf_parser
  import sdf_pkg::*;
#(
  parameter int TAG_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        advance,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output sdf_result_t result
);

  typedef enum logic [2:0] {
    PH_HEAD, PH_CODE, PH_LEN8, PH_LENHI, PH_LENLO, PH_BODY, PH_TRAIL, PH_ERR
  } phase_t;

  localparam logic [15:0] TAG_LEN = 16'(TAG_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] clen_r, clen_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [15:0] cap_r;
  logic        take;
  logic [15:0] blob;
  logic [15:0] ct;

  assign ct = blob - TAG_LEN;

  always_comb begin
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    clen_nxt   = clen_r;
    err_nxt    = err_r;
    take       = 1'b0;
    blob       = '0;
    result     = '0;
    unique case (phase_r)
      PH_HEAD: begin
        if (hidx_r < HEAD_LEN && in_byte == head_byte(hidx_r)) begin
          hidx_nxt = hidx_r + 3'd1;
          if (hidx_nxt == HEAD_LEN) begin
            phase_nxt = PH_CODE;
          end
        end else begin
          err_nxt   = ST_BAD_HEAD;
          phase_nxt = PH_ERR;
        end
      end
      PH_CODE: begin
        if (in_byte >= BSTR_INL_LO && in_byte <= BSTR_INL_HI) begin
          take = 1'b1;
          blob = {8'h00, in_byte - BSTR_INL_LO};
        end else if (in_byte == BSTR_LEN8) begin
          phase_nxt = PH_LEN8;
        end else if (in_byte == BSTR_LEN16) begin
          phase_nxt = PH_LENHI;
        end else begin
          err_nxt   = ST_BAD_CODE;
          phase_nxt = PH_ERR;
        end
      end
      PH_LEN8: begin
        take = 1'b1;
        blob = {8'h00, in_byte};
      end
      PH_LENHI: begin
        len_hi_nxt = in_byte;
        phase_nxt  = PH_LENLO;
      end
      PH_LENLO: begin
        take = 1'b1;
        blob = {len_hi_r, in_byte};
      end
      PH_BODY: begin
        result.data = in_byte;
        result.kind = (left_r > TAG_LEN) ? KIND_CIPHER : KIND_TAG;
        left_nxt    = left_r - 16'd1;
        if (left_nxt == 16'd0) begin
          phase_nxt = PH_TRAIL;
        end
      end
      PH_TRAIL, PH_ERR: begin
      end
      default: begin
      end
    endcase

    if (take) begin
      if (blob < TAG_LEN) begin
        err_nxt   = ST_BELOW_TAG;
        phase_nxt = PH_ERR;
      end else if (ct > cap_r) begin
        err_nxt   = ST_OVER_CAP;
        phase_nxt = PH_ERR;
      end else begin
        clen_nxt  = ct;
        left_nxt  = blob;
        phase_nxt = (blob == 16'd0) ? PH_TRAIL : PH_BODY;
      end
    end

    if (in_last) begin
      result.done = 1'b1;
      if (phase_nxt == PH_TRAIL) begin
        result.status     = ST_OK;
        result.cipher_len = clen_nxt;
      end else if (phase_nxt == PH_ERR) begin
        result.status = err_nxt;
      end else begin
        result.status = ST_SHORT;
      end
      phase_nxt  = PH_HEAD;
      hidx_nxt   = '0;
      len_hi_nxt = '0;
      left_nxt   = '0;
      clen_nxt   = '0;
      err_nxt    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEAD;
      hidx_r   <= '0;
      len_hi_r <= '0;
      left_r   <= '0;
      clen_r   <= '0;
      err_r    <= ST_OK;
      cap_r    <= CAPACITY_RST;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (advance) begin
        phase_r  <= phase_nxt;
        hidx_r   <= hidx_nxt;
        len_hi_r <= len_hi_nxt;
        left_r   <= left_nxt;
        clen_r   <= clen_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_last |=> phase_r == PH_HEAD && err_r == ST_OK && hidx_r == 3'd0)
    else $error("message state not cleared after last beat");

  a_head_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEAD |-> err_r == ST_OK)
    else $error("error code held while expecting head");

  a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> left_r != 16'd0)
    else $error("body phase with no bytes left");

endmodule

[design/sessiondata_envelope_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sessiondata_envelope_deframer
// Streaming deframer for a {"data": bstr} envelope. Body bytes are passed out
// as ciphertext or tag beats, and the last beat reports status and length.
// ----------------------------------------------------------------------------
// Path: a beat's result is presented from the result register, which follows
// the input register (input register, then result register).
// Throughput: one beat per cycle; the input register advances whenever the
// result register is empty or being drained.
// Reset: synchronous active-low rst_n clears both stages, the message state,
// and sets the capacity register to 512.
module sessiondata_envelope_deframer
  import sdf_pkg::*;
#(
  parameter int TAG_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [15:0] out_cipher_len,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        advance;
  logic        out_valid_r;
  sdf_result_t res;
  sdf_result_t res_r;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  sdf_parser #(
    .TAG_BYTES(TAG_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .advance    (advance),
    .in_byte    (s1_byte_r),
    .in_last    (s1_last_r),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = res_r.data;
  assign out_kind       = res_r.kind;
  assign out_done_res   = res_r.done;
  assign out_status     = res_r.status;
  assign out_cipher_len = res_r.cipher_len;

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NONE |-> out_byte == 8'h00)
    else $error("byte driven on a beat without kind");

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == ST_OK && out_cipher_len == 16'd0)
    else $error("status or length on a beat that is not the last");

  a_len_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_cipher_len == 16'd0)
    else $error("payload length reported with an error status");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input stage lost a beat during a stall");

endmodule
